/* hw/rtl/pptt_pkg.sv */
// pptt_pkg: shared types and codes for the packed parent tree table
package pptt_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_LIST  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ERR   = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_SCAN = 2'd2,
		S_FIN  = 2'd3
	} state_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [5:0] query_index;
		logic [5:0] parent_index;
		logic [1:0] label_in;
		logic [5:0] max_count;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] result_index;
		logic [1:0] label_out;
		logic [5:0] parent_out;
		logic [6:0] node_total;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic [1:0] label;
		logic [5:0] parent;
	} node_t;

endpackage

/* hw/rtl/pptt_store.sv */
// pptt_store: node memory, one write port and one registered read port
module pptt_store #(
	parameter int DEPTH = 60,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  pptt_pkg::node_t       wdata,
	input  logic [AW-1:0]         raddr,
	output pptt_pkg::node_t       rdata
);

	pptt_pkg::node_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/packed_parent_tree_table.sv */
// packed_parent_tree_table: tree store top level with command sequencer
//
//   channel   ports                     handshake
//   command   start, busy, req          taken when start && !busy
//   result    rsp_valid, rsp            one cycle per word, no back-pressure
//
// clear and add child answer from idle; read node passes the read state (one memory read).
// list root children scans the stored nodes: it issues one memory read per cycle
// and checks the parent in the cycle after; max_count can end it early.
// reset and clear leave only the root; entries at or above the node count
// read as zero, so no clearing pass is needed. the receiver cannot stall.
module packed_parent_tree_table #(
	parameter int MAX_NODES = 60
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pptt_pkg::req_t  req,
	output logic            rsp_valid,
	output pptt_pkg::rsp_t  rsp
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam logic [6:0] MaxCnt = 7'(MAX_NODES);

	pptt_pkg::state_t state_q, state_d;
	logic [6:0]       count_q, count_d;
	logic [6:0]       issue_q, issue_d;
	logic             chk_v_s1, chk_v_d;
	logic [5:0]       chk_idx_s1, chk_idx_d;
	logic [5:0]       n_q, n_d;
	logic [5:0]       cap_q, cap_d;
	logic             pend_v_q, pend_v_d;
	logic [5:0]       pend_idx_q, pend_idx_d;
	logic             rd_err_s1, rd_err_d;
	logic             rd_hit_s1, rd_hit_d;
	pptt_pkg::rsp_t   rsp_q, rsp_d;
	logic             rsp_v_q, rsp_v_d;

	logic             we;
	logic [AW-1:0]    waddr;
	pptt_pkg::node_t  wdata;
	logic [AW-1:0]    raddr;
	pptt_pkg::node_t  rdata;
	logic             found;

	pptt_store #(
		.DEPTH (MAX_NODES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy      = (state_q != pptt_pkg::S_IDLE);
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	assign found = chk_v_s1 && (rdata.parent == 6'd0);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		issue_d    = issue_q;
		chk_v_d    = 1'b0;
		chk_idx_d  = chk_idx_s1;
		n_d        = n_q;
		cap_d      = cap_q;
		pend_v_d   = pend_v_q;
		pend_idx_d = pend_idx_q;
		rd_err_d   = rd_err_s1;
		rd_hit_d   = rd_hit_s1;
		rsp_d      = '0;
		rsp_v_d    = 1'b0;
		we         = 1'b0;
		waddr      = count_q[AW-1:0];
		wdata      = '{label: req.label_in, parent: req.parent_index};
		raddr      = issue_q[AW-1:0];

		case (state_q)
			pptt_pkg::S_IDLE: begin
				if (start) begin
					case (req.cmd)
						pptt_pkg::CMD_CLEAR: begin
							count_d          = 7'd1;
							rsp_d.status     = pptt_pkg::ST_OK;
							rsp_d.node_total = 7'd1;
							rsp_d.last       = 1'b1;
							rsp_v_d          = 1'b1;
						end
						pptt_pkg::CMD_ADD: begin
							rsp_d.last = 1'b1;
							rsp_v_d    = 1'b1;
							if (count_q >= MaxCnt || {1'b0, req.parent_index} >= count_q) begin
								rsp_d.status     = pptt_pkg::ST_ERR;
								rsp_d.node_total = count_q;
							end else begin
								we                 = 1'b1;
								count_d            = count_q + 7'd1;
								rsp_d.status       = pptt_pkg::ST_OK;
								rsp_d.result_index = count_q[5:0];
								rsp_d.node_total   = count_q + 7'd1;
							end
						end
						pptt_pkg::CMD_READ: begin
							raddr    = req.query_index[AW-1:0];
							rd_err_d = ({1'b0, req.query_index} >= MaxCnt);
							// root and unused entries read as zero
							rd_hit_d = (req.query_index != 6'd0)
								&& ({1'b0, req.query_index} < count_q);
							state_d  = pptt_pkg::S_READ;
						end
						pptt_pkg::CMD_LIST: begin
							n_d      = 6'd0;
							cap_d    = req.max_count;
							pend_v_d = 1'b0;
							issue_d  = 7'd1;
							state_d  = (req.max_count == 6'd0) ? pptt_pkg::S_FIN
								: pptt_pkg::S_SCAN;
						end
						default: begin
							state_d = pptt_pkg::S_IDLE;
						end
					endcase
				end
			end
			pptt_pkg::S_READ: begin
				rsp_d.status     = rd_err_s1 ? pptt_pkg::ST_ERR : pptt_pkg::ST_OK;
				rsp_d.label_out  = (rd_hit_s1 && !rd_err_s1) ? rdata.label : 2'd0;
				rsp_d.parent_out = (rd_hit_s1 && !rd_err_s1) ? rdata.parent : 6'd0;
				rsp_d.node_total = count_q;
				rsp_d.last       = 1'b1;
				rsp_v_d          = 1'b1;
				state_d          = pptt_pkg::S_IDLE;
			end
			pptt_pkg::S_SCAN: begin
				if (issue_q < count_q) begin
					chk_v_d   = 1'b1;
					chk_idx_d = issue_q[5:0];
					issue_d   = issue_q + 7'd1;
				end
				// a hit is held back one step so the final word can carry last
				if (found) begin
					if (pend_v_q) begin
						rsp_d.status       = pptt_pkg::ST_OK;
						rsp_d.result_index = pend_idx_q;
						rsp_d.node_total   = count_q;
						rsp_v_d            = 1'b1;
					end
					pend_v_d   = 1'b1;
					pend_idx_d = chk_idx_s1;
					n_d        = n_q + 6'd1;
				end
				if ((found && (n_q + 6'd1) == cap_q) || (!chk_v_s1 && issue_q >= count_q)) begin
					state_d = pptt_pkg::S_FIN;
				end
			end
			pptt_pkg::S_FIN: begin
				rsp_d.status       = pend_v_q ? pptt_pkg::ST_OK : pptt_pkg::ST_EMPTY;
				rsp_d.result_index = pend_v_q ? pend_idx_q : 6'd0;
				rsp_d.node_total   = count_q;
				rsp_d.last         = 1'b1;
				rsp_v_d            = 1'b1;
				state_d            = pptt_pkg::S_IDLE;
			end
			default: begin
				state_d = pptt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pptt_pkg::S_IDLE;
			count_q  <= 7'd1;
			chk_v_s1 <= 1'b0;
			pend_v_q <= 1'b0;
			rsp_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			chk_v_s1 <= chk_v_d;
			pend_v_q <= pend_v_d;
			rsp_v_q  <= rsp_v_d;
		end
	end

	always_ff @(posedge clk) begin
		issue_q    <= issue_d;
		chk_idx_s1 <= chk_idx_d;
		n_q        <= n_d;
		cap_q      <= cap_d;
		pend_idx_q <= pend_idx_d;
		rd_err_s1  <= rd_err_d;
		rd_hit_s1  <= rd_hit_d;
		rsp_q      <= rsp_d;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= 7'd1) && (count_q <= MaxCnt))
		else $error("node count out of range");

	a_nonlast_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_v_q && !rsp_q.last) |-> (state_q == pptt_pkg::S_SCAN || state_q == pptt_pkg::S_FIN))
		else $error("non-final word outside a listing");

	a_final_word: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (rsp_v_q && rsp_q.last))
		else $error("busy dropped without a final word");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pptt_pkg::S_SCAN) |-> (n_q < cap_q))
		else $error("listing ran past its limit");
`endif

endmodule

/* sim/packed_parent_tree_table_tb.sv */
// packed_parent_tree_table_tb: self-checking testbench for the packed parent tree table
module packed_parent_tree_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TREE_CAP = 60;
	localparam int CMD_TARGET = 310;

	// tracks the tree contents and the result words it should produce
	class tree_scoreboard;
		pptt_pkg::node_t nodes[TREE_CAP];
		logic [6:0]      count;
		pptt_pkg::rsp_t  due[$];
		int              errors;

		function new();
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (nodes[i]) nodes[i] = '0;
			count = 7'd1;
		endfunction

		function pptt_pkg::rsp_t word(pptt_pkg::status_t st, logic [5:0] idx,
			pptt_pkg::node_t nd, logic fin);
			pptt_pkg::rsp_t w;
			w.status       = st;
			w.result_index = idx;
			w.label_out    = nd.label;
			w.parent_out   = nd.parent;
			w.node_total   = count;
			w.last         = fin;
			return w;
		endfunction

		// work out the words that one accepted command causes
		function void note(pptt_pkg::req_t r);
			int n;
			case (r.cmd)
				pptt_pkg::CMD_CLEAR: begin
					wipe();
					due.push_back(word(pptt_pkg::ST_OK, '0, '0, 1'b1));
				end
				pptt_pkg::CMD_ADD: begin
					if (count >= TREE_CAP || r.parent_index >= count) begin
						due.push_back(word(pptt_pkg::ST_ERR, '0, '0, 1'b1));
					end else begin
						nodes[count].label  = r.label_in;
						nodes[count].parent = r.parent_index;
						count = count + 7'd1;
						due.push_back(word(pptt_pkg::ST_OK, 6'(count - 7'd1), '0, 1'b1));
					end
				end
				pptt_pkg::CMD_READ: begin
					if (r.query_index >= TREE_CAP)
						due.push_back(word(pptt_pkg::ST_ERR, '0, '0, 1'b1));
					else
						due.push_back(word(pptt_pkg::ST_OK, '0, nodes[r.query_index], 1'b1));
				end
				default: begin
					n = 0;
					for (int i = 1; i < count && n < r.max_count; i++) begin
						if (nodes[i].parent == 6'd0) begin
							due.push_back(word(pptt_pkg::ST_OK, 6'(i), '0, 1'b0));
							n++;
						end
					end
					if (n == 0)
						due.push_back(word(pptt_pkg::ST_EMPTY, '0, '0, 1'b1));
					else
						due[due.size() - 1].last = 1'b1;
				end
			endcase
		endfunction

		task report_mismatch(string what, logic [6:0] got, logic [6:0] want);
			$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
			errors++;
		endtask

		task check(pptt_pkg::rsp_t got);
			pptt_pkg::rsp_t want;
			if (due.size() == 0) begin
				report_mismatch("unexpected word, index", 7'(got.result_index), '0);
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 7'(got.status), 7'(want.status));
			if (got.result_index !== want.result_index)
				report_mismatch("result_index", 7'(got.result_index),
					7'(want.result_index));
			if (got.label_out !== want.label_out)
				report_mismatch("label_out", 7'(got.label_out), 7'(want.label_out));
			if (got.parent_out !== want.parent_out)
				report_mismatch("parent_out", 7'(got.parent_out), 7'(want.parent_out));
			if (got.node_total !== want.node_total)
				report_mismatch("node_total", got.node_total, want.node_total);
			if (got.last !== want.last)
				report_mismatch("last", 7'(got.last), 7'(want.last));
		endtask

		task flag_leftover();
			if (due.size() != 0)
				report_mismatch("words never received", 7'(due.size()), '0);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	pptt_pkg::req_t req;
	logic rsp_valid;
	pptt_pkg::rsp_t rsp;

	tree_scoreboard sb;
	int cmds_sent;
	int burst_left;
	bit refilled;
	int guard;

	packed_parent_tree_table #(.MAX_NODES(TREE_CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid)
			sb.check(rsp);
	end

	function int rnd6();
		return $urandom_range(0, 63);
	endfunction

	function int rnd2();
		return $urandom_range(0, 3);
	endfunction

	// often root children so the listings have something to find
	function int valid_parent();
		int c;
		c = int'(sb.count);
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, c - 1);
	endfunction

	// drive one command word, called at a falling edge and returning at one
	task automatic issue(pptt_pkg::cmd_t c, int q, int p, int l, int m);
		pptt_pkg::req_t r;
		int gap;
		r.cmd          = c;
		r.query_index  = q[5:0];
		r.parent_index = p[5:0];
		r.label_in     = l[1:0];
		r.max_count    = m[5:0];
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
			                                         : $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		sb.note(r);
		cmds_sent++;
		@(negedge clk);
	endtask

	// grow the tree until it is full, then knock on the full store
	task automatic fill_tree();
		while (sb.count < TREE_CAP) begin
			if ($urandom_range(0, 9) == 0)
				issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), 63);
			else if ($urandom_range(0, 9) == 0)
				issue(pptt_pkg::CMD_READ, $urandom_range(0, int'(sb.count)), rnd6(), rnd2(),
					rnd6());
			else
				issue(pptt_pkg::CMD_ADD, rnd6(), valid_parent(), rnd2(), rnd6());
		end
		repeat (3) issue(pptt_pkg::CMD_ADD, rnd6(), $urandom_range(0, TREE_CAP - 1), rnd2(),
			rnd6());
		issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), 63);
		issue(pptt_pkg::CMD_READ, TREE_CAP - 1, rnd6(), rnd2(), rnd6());
	endtask

	task automatic random_cmd();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			issue(pptt_pkg::CMD_CLEAR, rnd6(), rnd6(), rnd2(), rnd6());
		end else if (pick < 55) begin
			if (sb.count < TREE_CAP && $urandom_range(0, 99) < 85)
				issue(pptt_pkg::CMD_ADD, rnd6(), valid_parent(), rnd2(), rnd6());
			else
				issue(pptt_pkg::CMD_ADD, rnd6(), rnd6(), rnd2(), rnd6());
		end else if (pick < 75) begin
			if ($urandom_range(0, 9) < 7)
				issue(pptt_pkg::CMD_READ, $urandom_range(0, int'(sb.count) + 1), rnd6(),
					rnd2(), rnd6());
			else
				issue(pptt_pkg::CMD_READ, rnd6(), rnd6(), rnd2(), rnd6());
		end else begin
			if ($urandom_range(0, 3) == 0)
				issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), rnd6());
			else
				issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), $urandom_range(0, 8));
		end
	endtask

	initial begin
		start      = 1'b0;
		req        = '0;
		arst_n     = 1'b0;
		cmds_sent  = 0;
		burst_left = 0;
		refilled   = 1'b0;
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fresh tree: root only, reads past the count and past the store
		issue(pptt_pkg::CMD_READ, 0, rnd6(), rnd2(), rnd6());
		issue(pptt_pkg::CMD_READ, TREE_CAP - 1, rnd6(), rnd2(), rnd6());
		issue(pptt_pkg::CMD_READ, TREE_CAP, rnd6(), rnd2(), rnd6());
		issue(pptt_pkg::CMD_READ, 63, rnd6(), rnd2(), rnd6());
		issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), 63);
		// parent not there yet, then adds under existing parents
		issue(pptt_pkg::CMD_ADD, rnd6(), 1, 3, rnd6());
		issue(pptt_pkg::CMD_ADD, rnd6(), 63, 3, rnd6());
		issue(pptt_pkg::CMD_ADD, rnd6(), 0, 3, rnd6());
		issue(pptt_pkg::CMD_ADD, rnd6(), 1, 2, rnd6());
		issue(pptt_pkg::CMD_ADD, rnd6(), 0, 1, rnd6());
		issue(pptt_pkg::CMD_ADD, rnd6(), 2, 0, rnd6());
		issue(pptt_pkg::CMD_READ, 1, rnd6(), rnd2(), rnd6());
		issue(pptt_pkg::CMD_READ, 4, rnd6(), rnd2(), rnd6());
		issue(pptt_pkg::CMD_READ, 5, rnd6(), rnd2(), rnd6());
		// zero cap lists nothing even with root children present
		issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), 0);
		issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), 1);
		issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), 63);
		issue(pptt_pkg::CMD_ADD, rnd6(), 4, 3, rnd6());
		issue(pptt_pkg::CMD_ADD, rnd6(), 0, 2, rnd6());
		issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), 2);
		issue(pptt_pkg::CMD_CLEAR, 63, 63, 3, 63);
		issue(pptt_pkg::CMD_READ, 1, rnd6(), rnd2(), rnd6());
		issue(pptt_pkg::CMD_LIST, rnd6(), rnd6(), rnd2(), 63);
		issue(pptt_pkg::CMD_ADD, rnd6(), 0, 0, rnd6());

		fill_tree();
		while (cmds_sent < CMD_TARGET) begin
			if (!refilled && cmds_sent >= 190) begin
				issue(pptt_pkg::CMD_CLEAR, rnd6(), rnd6(), rnd2(), rnd6());
				fill_tree();
				refilled = 1'b1;
			end else begin
				random_cmd();
			end
		end
		start <= 1'b0;

		guard = 0;
		while (sb.due.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
		sb.flag_leftover();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

/* packed_parent_tree_table.f */
hw/rtl/pptt_pkg.sv
hw/rtl/pptt_store.sv
hw/rtl/packed_parent_tree_table.sv
sim/packed_parent_tree_table_tb.sv
